// ----- rtl/csv_field_tokenizer_defines.svh -----
// ----------------------------------------------------------------------------
// csv_field_tokenizer_defines.svh
// Assertion macros shared by the tokenizer RTL.
// ----------------------------------------------------------------------------
`ifndef CSV_FIELD_TOKENIZER_DEFINES_SVH
`define CSV_FIELD_TOKENIZER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CSVTOK_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define CSVTOK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/csvtok_pkg.sv -----
// ----------------------------------------------------------------------------
// csvtok_pkg
// Types and constants shared by the CSV field tokenizer.
// ----------------------------------------------------------------------------
package csvtok_pkg;

    localparam int MAX_FIELDS_DEF = 256;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_QUOTE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECORD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NFIELD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIPHD = 3'd4;

    localparam logic [7:0] BSLASH_BYTE = 8'h5C;
    localparam logic [7:0] DQUOTE_BYTE = 8'h22;
    localparam logic [7:0] TAB_BYTE    = 8'h09;

    localparam int OUT_TDATA_W = 56;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_ESCAPE = 2'd1,
        ERR_QUOTE  = 2'd2,
        ERR_ROW    = 2'd3
    } t_err;

    typedef struct packed {
        logic [7:0] quote_char;
        logic [7:0] sep_char;
        logic [7:0] record_char;
        logic [7:0] last_idx;
        logic       skip_header;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        data_valid;
        logic [7:0]  field_index;
        logic        field_end;
        logic        field_null;
        logic        row_end;
        logic [31:0] row_count;
        logic [1:0]  error_code;
    } t_res;

endpackage

// ----- rtl/csvtok_cfg.sv -----
// ----------------------------------------------------------------------------
// csvtok_cfg
// Configuration registers and last-field index derivation.
// ----------------------------------------------------------------------------
module csvtok_cfg
    import csvtok_pkg::*;
#(
    parameter int MAX_FIELDS = MAX_FIELDS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    localparam int CAP_INT = (MAX_FIELDS < 256) ? MAX_FIELDS : 256;
    localparam logic [CFG_DATA_W-1:0] CAP = CFG_DATA_W'(CAP_INT);

    logic [7:0]            r_quote;
    logic [7:0]            r_sep;
    logic [7:0]            r_record;
    logic [CFG_DATA_W-1:0] r_nfields;
    logic                  r_skip;
    logic [CFG_DATA_W-1:0] w_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quote   <= DQUOTE_BYTE;
            r_sep     <= 8'd44;
            r_record  <= 8'd10;
            r_nfields <= CFG_DATA_W'(1);
            r_skip    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_QUOTE:  r_quote   <= i_cfg_data[7:0];
                CFG_SEP:    r_sep     <= i_cfg_data[7:0];
                CFG_RECORD: r_record  <= i_cfg_data[7:0];
                CFG_NFIELD: r_nfields <= i_cfg_data;
                CFG_SKIPHD: r_skip    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // zero acts as one, clamp to the field cap
    always_comb begin
        w_n = (r_nfields == '0) ? CFG_DATA_W'(1) : r_nfields;
        if (w_n > CAP) w_n = CAP;
    end

    assign o_cfg.quote_char  = r_quote;
    assign o_cfg.sep_char    = r_sep;
    assign o_cfg.record_char = r_record;
    assign o_cfg.last_idx    = 8'(w_n - CFG_DATA_W'(1));
    assign o_cfg.skip_header = r_skip;

endmodule

// ----- rtl/csvtok_core.sv -----
// ----------------------------------------------------------------------------
// csvtok_core
// Parser state and the per-beat next-state / result logic.
// ----------------------------------------------------------------------------
module csvtok_core
    import csvtok_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_res       o_res,
    output t_err       o_err
);

    logic        r_in_field, n_in_field;
    logic        r_quoted, n_quoted;
    logic        r_esc, n_esc;
    logic        r_expect_sep, n_expect_sep;
    logic        r_has_content, n_has_content;
    logic [7:0]  r_field, n_field;
    logic [31:0] r_rows, n_rows;
    t_err        r_err, n_err;

    logic       w_is_last;
    logic [7:0] w_term;
    logic       w_escapes;
    logic       w_header;
    logic       w_content, w_fend, w_fnull, w_rend;

    always_comb begin
        w_is_last = r_field >= i_cfg.last_idx;
        w_term    = w_is_last ? i_cfg.record_char : i_cfg.sep_char;
        w_escapes = i_cfg.sep_char != TAB_BYTE;
        w_header  = i_cfg.skip_header && (r_rows == '0);

        n_in_field    = r_in_field;
        n_quoted      = r_quoted;
        n_esc         = r_esc;
        n_expect_sep  = r_expect_sep;
        n_has_content = r_has_content;
        n_field       = r_field;
        n_rows        = r_rows;
        n_err         = r_err;
        w_content     = 1'b0;
        w_fend        = 1'b0;
        w_fnull       = 1'b0;
        w_rend        = 1'b0;

        if (r_err == ERR_NONE) begin
            if (r_expect_sep) begin
                if (i_byte == w_term) begin
                    w_fend  = 1'b1;
                    w_fnull = !r_has_content;
                    w_rend  = w_is_last;
                end else begin
                    n_err = ERR_QUOTE;
                end
            end else if (w_escapes && r_esc) begin
                if (i_byte != BSLASH_BYTE && i_byte != DQUOTE_BYTE) begin
                    n_err = ERR_ESCAPE;
                end else begin
                    n_esc     = 1'b0;
                    w_content = 1'b1;
                end
            end else if (w_escapes && i_byte == BSLASH_BYTE) begin
                n_esc = 1'b1;
                if (!r_in_field) begin
                    n_in_field    = 1'b1;
                    n_quoted      = 1'b0;
                    n_has_content = 1'b0;
                end
            end else if (!r_in_field) begin
                if (i_byte == i_cfg.quote_char) begin
                    n_in_field    = 1'b1;
                    n_quoted      = 1'b1;
                    n_has_content = 1'b0;
                end else if (i_byte == w_term) begin
                    w_fend  = 1'b1;
                    w_fnull = 1'b1;
                    w_rend  = w_is_last;
                end else begin
                    n_in_field = 1'b1;
                    n_quoted   = 1'b0;
                    w_content  = 1'b1;
                end
            end else if (r_quoted) begin
                if (i_byte == i_cfg.quote_char) n_expect_sep = 1'b1;
                else w_content = 1'b1;
            end else begin
                if (i_byte == w_term) begin
                    w_fend  = 1'b1;
                    w_fnull = !r_has_content;
                    w_rend  = w_is_last;
                end else begin
                    w_content = 1'b1;
                end
            end

            if (w_content) n_has_content = 1'b1;
            if (w_fend) begin
                n_in_field    = 1'b0;
                n_quoted      = 1'b0;
                n_expect_sep  = 1'b0;
                n_has_content = 1'b0;
                n_esc         = 1'b0;
                n_field       = w_is_last ? 8'd0 : r_field + 8'd1;
                if (w_rend && r_rows != '1) n_rows = r_rows + 32'd1;
            end
            // file ended away from a row boundary
            if (i_last && n_err == ERR_NONE &&
                (n_in_field || n_expect_sep || n_esc || n_field != 8'd0))
                n_err = ERR_ROW;
            if (n_err != ERR_NONE) begin
                w_content = 1'b0;
                w_fend    = 1'b0;
                w_fnull   = 1'b0;
                w_rend    = 1'b0;
            end
        end

        if (w_header) begin
            w_content = 1'b0;
            w_fend    = 1'b0;
            w_fnull   = 1'b0;
            w_rend    = 1'b0;
        end

        o_res.data_byte   = w_content ? i_byte : 8'd0;
        o_res.data_valid  = w_content;
        o_res.field_index = r_field;
        o_res.field_end   = w_fend;
        o_res.field_null  = w_fend && w_fnull;
        o_res.row_end     = w_rend;
        o_res.row_count   = (i_cfg.skip_header && n_rows != '0) ? n_rows - 32'd1 : n_rows;
        o_res.error_code  = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_field    <= 1'b0;
            r_quoted      <= 1'b0;
            r_esc         <= 1'b0;
            r_expect_sep  <= 1'b0;
            r_has_content <= 1'b0;
            r_field       <= 8'd0;
            r_rows        <= 32'd0;
            r_err         <= ERR_NONE;
        end else if (i_step) begin
            r_in_field    <= n_in_field;
            r_quoted      <= n_quoted;
            r_esc         <= n_esc;
            r_expect_sep  <= n_expect_sep;
            r_has_content <= n_has_content;
            r_field       <= n_field;
            r_rows        <= n_rows;
            r_err         <= n_err;
        end
    end

    assign o_err = r_err;

endmodule

// ----- rtl/csv_field_tokenizer.sv -----
// Path: an accepted beat goes to the input register, then through the parser logic
// into the result register. Throughput: one byte per cycle while the output is
// not stalled; the parser step lies between the two registers, and while a result
// stalls, one more beat waits in the input register.
// Reset: synchronous, active low; clears parser state, error, row count and
// restores configuration defaults.
// ----------------------------------------------------------------------------
// csv_field_tokenizer
// Streaming CSV tokenizer: bytes in, one tagged result beat per byte out.
// ----------------------------------------------------------------------------
`include "csv_field_tokenizer_defines.svh"

module csv_field_tokenizer
    import csvtok_pkg::*;
#(
    parameter int MAX_FIELDS = MAX_FIELDS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [7:0]             i_s_tdata,   // [7:0] in_byte
    input  logic                   i_s_tlast,   // in_last
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // [7:0] data_byte, [15:8] field_index, [16] field_end, [17] field_null,
    // [49:18] row_count, [51:50] error_code, [55:52] zero
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    output logic                   o_m_tuser,   // data_valid
    output logic                   o_m_tlast,   // row_end
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg       w_cfg;
    t_res       w_res;
    t_err       w_err;
    logic       w_adv;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    t_res       r_res;

    csvtok_cfg #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    csvtok_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_step  (w_adv),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_res   (w_res),
        .o_err   (w_err)
    );

    // held beat moves on when the result register is free or being drained
    assign w_adv      = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) r_res <= w_res;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_res.error_code, r_res.row_count, r_res.field_null,
                         r_res.field_end, r_res.field_index, r_res.data_byte};
    assign o_m_tuser  = r_res.data_valid;
    assign o_m_tlast  = r_res.row_end;

    `CSVTOK_ASSERT_IMPL(a_no_overrun, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !r_in_valid || w_adv, "input beat accepted over a held beat")
    `CSVTOK_ASSERT_NEXT(a_err_sticky, i_clk, i_rst_n, w_err != ERR_NONE, w_err == $past(w_err), "sticky error changed")
    `CSVTOK_ASSERT_IMPL(a_err_quiet, i_clk, i_rst_n, r_out_valid && r_res.error_code != ERR_NONE, !r_res.data_valid && !r_res.field_end && !r_res.row_end, "activity reported after error")

endmodule
